FILE: hw/rtl/npcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, constants and helpers for the nearest palette colour mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

   localparam int unsigned PAL_ENTRIES = 16;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned CH_W        = 5;
   localparam int unsigned DIST_W      = 7;
   localparam int unsigned WORDS       = 4;
   localparam int unsigned WORD_W      = 64;
   localparam int unsigned ENTRY_W     = 16;
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic [1:0] MODE_TRUE    = 2'd0;
   localparam logic [1:0] MODE_GRAY    = 2'd1;
   localparam logic [1:0] MODE_INDEXED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_3  = 3'd4;

   typedef logic [CH_W-1:0]                  chan_type;
   typedef logic [DIST_W-1:0]                dist_type;
   typedef logic [IDX_W-1:0]                 idx_type;
   typedef dist_type [PAL_ENTRIES-1:0]       dist_array_type;
   typedef logic [WORDS-1:0][WORD_W-1:0]     palette_type;

   // widen a 3-bit channel to five bits by bit replication
   function automatic chan_type widen3(input logic [2:0] v);
      return {v, v[2:1]};
   endfunction

   function automatic chan_type absdiff(input chan_type a, input chan_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage : npcm_pkg
`default_nettype wire

FILE: hw/rtl/nearest_palette_color_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Maps each pixel word to the nearest of 16 palette colours, or passes the
// byte through when mode bit 1 is set (indexed and spare modes).
// Each accepted word passes the input, distance and result registers in turn;
// rsp_tvalid rises once its result word is held in the result register.
// Throughput: one word per cycle unless stalled; the three pipeline registers (input,
// distance, result) advance together whenever the result register is empty
// or drains.
// Reset: synchronous; clears all valid flags, colour mode and palette.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // red_level [7:0], green_level [15:8], blue_level [23:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // pixel_index [7:0]
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [63:0] csr_wdata
);

   logic                  advance;
   logic [1:0]            mode_ff;
   npcm_pkg::palette_type palette_ff;

   logic        s1_valid_ff;
   logic [7:0]  s1_red_ff, s1_green_ff, s1_blue_ff;

   npcm_pkg::chan_type       s2_red, s2_green, s2_blue;
   npcm_pkg::dist_array_type s2_dist_in;
   npcm_pkg::dist_array_type s2_dist_ff;
   logic                     s2_valid_ff;
   logic                     s2_pass_ff;
   logic [7:0]               s2_byte_ff;

   npcm_pkg::idx_type s3_index;
   logic [7:0]        rsp_data_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_pass_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= npcm_pkg::MODE_TRUE;
         palette_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            npcm_pkg::CSR_COLOR_MODE: mode_ff       <= csr_wdata[1:0];
            npcm_pkg::CSR_PALETTE_0:  palette_ff[0] <= csr_wdata;
            npcm_pkg::CSR_PALETTE_1:  palette_ff[1] <= csr_wdata;
            npcm_pkg::CSR_PALETTE_2:  palette_ff[2] <= csr_wdata;
            npcm_pkg::CSR_PALETTE_3:  palette_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage 1: capture input word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_red_ff   <= req_tdata[7:0];
         s1_green_ff <= req_tdata[15:8];
         s1_blue_ff  <= req_tdata[23:16];
      end
   end

   // stage 2: distances to all entries
   always_comb begin
      s2_red   = s1_red_ff[7:3];
      s2_green = s1_green_ff[7:3];
      s2_blue  = s1_blue_ff[7:3];
      if (mode_ff == npcm_pkg::MODE_GRAY) begin
         s2_green = s1_red_ff[7:3];
         s2_blue  = s1_red_ff[7:3];
      end
   end

   npcm_dist u_dist (
      .red      (s2_red),
      .green    (s2_green),
      .blue     (s2_blue),
      .palette  (palette_ff),
      .distance (s2_dist_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_dist_ff <= s2_dist_in;
         s2_pass_ff <= mode_ff[1];
         s2_byte_ff <= s1_red_ff;
      end
   end

   // stage 3: pick the entry
   npcm_select u_select (
      .distance (s2_dist_ff),
      .index    (s3_index)
   );

   assign rsp_data_in = s2_pass_ff ? s2_byte_ff : 8'(s3_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_pass_ff <= s2_pass_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pass_ff |-> rsp_data_ff[7:4] == 4'd0)
      else $error("palette index out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s2_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_red_ff))
      else $error("stage 1 word lost during stall");

   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !advance |=> s2_valid_ff && $stable(s2_dist_ff))
      else $error("stage 2 distances changed during stall");

endmodule : nearest_palette_color_mapper
`default_nettype wire

FILE: hw/rtl/npcm_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_dist
// Sum of absolute channel differences from one pixel to all palette entries.
// ----------------------------------------------------------------------------
module npcm_dist (
   input  wire npcm_pkg::chan_type       red,
   input  wire npcm_pkg::chan_type       green,
   input  wire npcm_pkg::chan_type       blue,
   input  wire npcm_pkg::palette_type    palette,
   output npcm_pkg::dist_array_type      distance
);

   genvar k;
   generate
      for (k = 0; k < npcm_pkg::PAL_ENTRIES; k++) begin : g_entry
         localparam int unsigned WSEL = k / npcm_pkg::WORDS;
         localparam int unsigned ESEL = (k % npcm_pkg::WORDS) * npcm_pkg::ENTRY_W;
         logic [npcm_pkg::ENTRY_W-1:0] entry;
         npcm_pkg::chan_type pr, pg, pb;
         npcm_pkg::chan_type dr, dg, db;

         assign entry = palette[WSEL][ESEL +: npcm_pkg::ENTRY_W];
         assign pr    = npcm_pkg::widen3(entry[3:1]);
         assign pg    = npcm_pkg::widen3(entry[7:5]);
         assign pb    = npcm_pkg::widen3(entry[11:9]);
         assign dr    = npcm_pkg::absdiff(pr, red);
         assign dg    = npcm_pkg::absdiff(pg, green);
         assign db    = npcm_pkg::absdiff(pb, blue);
         assign distance[k] = npcm_pkg::dist_type'(dr) + npcm_pkg::dist_type'(dg)
                            + npcm_pkg::dist_type'(db);
      end
   endgenerate

endmodule : npcm_dist
`default_nettype wire

FILE: hw/rtl/npcm_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_select
// Pairwise tree that picks the first exact match, else the last nearest entry.
// ----------------------------------------------------------------------------
module npcm_select (
   input  wire npcm_pkg::dist_array_type distance,
   output npcm_pkg::idx_type             index
);

   localparam int unsigned LEVELS = npcm_pkg::IDX_W;

   npcm_pkg::dist_type lvl_d   [0:LEVELS][0:npcm_pkg::PAL_ENTRIES-1];
   npcm_pkg::idx_type  lvl_idx [0:LEVELS][0:npcm_pkg::PAL_ENTRIES-1];

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < npcm_pkg::PAL_ENTRIES; i++) begin
            lvl_d[l][i]   = '0;
            lvl_idx[l][i] = '0;
         end
      end
      for (int i = 0; i < npcm_pkg::PAL_ENTRIES; i++) begin
         lvl_d[0][i]   = distance[i];
         lvl_idx[0][i] = npcm_pkg::idx_type'(i);
      end
      // lower half wins on an exact match, upper half wins ties otherwise
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (npcm_pkg::PAL_ENTRIES >> (l + 1)); i++) begin
            if (lvl_d[l][2*i] != '0 && lvl_d[l][2*i+1] <= lvl_d[l][2*i]) begin
               lvl_d[l+1][i]   = lvl_d[l][2*i+1];
               lvl_idx[l+1][i] = lvl_idx[l][2*i+1];
            end else begin
               lvl_d[l+1][i]   = lvl_d[l][2*i];
               lvl_idx[l+1][i] = lvl_idx[l][2*i];
            end
         end
      end
   end

   assign index = lvl_idx[LEVELS][0];

endmodule : npcm_select
`default_nettype wire

FILE: tb/tb_nearest_palette_color_mapper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_mapper
// Streams pixel words through the palette mapper under random source gaps and
// sink stalls, across true colour, grayscale, indexed and spare mode settings
// and a range of palettes (cleared, saturated, two-shade and random). Every index
// word leaving the block is checked in order against a behavioural mapper.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_mapper;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         RANDOM_PHASES = 12;
   localparam int         PHASE_PIXELS  = 78;

   typedef logic [npcm_pkg::CSR_IDX_W-1:0] csr_idx_type;

   class colour_scoreboard;
      logic [1:0]  mode;
      logic [63:0] pal [npcm_pkg::WORDS];
      logic [7:0]  expected_indices [$];
      int          errors;
      int          pixels_seen;
      int          exact_hits;

      function new();
         mode = npcm_pkg::MODE_TRUE;
         foreach (pal[w]) pal[w] = '0;
         errors = 0;
         pixels_seen = 0;
         exact_hits = 0;
      endfunction

      static function int widen_channel(logic [2:0] v);
         return int'(v) * 4 + int'(v) / 2;
      endfunction

      static function int abs_gap(int a, int b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void set_reg(csr_idx_type idx, logic [63:0] value);
         case (idx)
            npcm_pkg::CSR_COLOR_MODE: mode = value[1:0];
            npcm_pkg::CSR_PALETTE_0: pal[0] = value;
            npcm_pkg::CSR_PALETTE_1: pal[1] = value;
            npcm_pkg::CSR_PALETTE_2: pal[2] = value;
            npcm_pkg::CSR_PALETTE_3: pal[3] = value;
            default: ;
         endcase
      endfunction

      function logic [15:0] entry(int k);
         return pal[k / 4][(k % 4) * npcm_pkg::ENTRY_W +: npcm_pkg::ENTRY_W];
      endfunction

      function logic [7:0] nearest_index(logic [23:0] px);
         int r, g, b, k, d, best, best_d;
         logic [15:0] e;
         if (mode[1]) return px[7:0];
         r = int'(px[7:3]);
         g = (mode == npcm_pkg::MODE_GRAY) ? r : int'(px[15:11]);
         b = (mode == npcm_pkg::MODE_GRAY) ? r : int'(px[23:19]);
         best = 0;
         best_d = 1000;
         for (k = 0; k < npcm_pkg::PAL_ENTRIES; k++) begin
            e = entry(k);
            d = abs_gap(widen_channel(e[3:1]), r) + abs_gap(widen_channel(e[7:5]), g)
                + abs_gap(widen_channel(e[11:9]), b);
            if (d <= best_d) begin
               best = k;
               best_d = d;
               if (d == 0) begin
                  exact_hits++;
                  break;
               end
            end
         end
         return 8'(best);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_pixel(logic [23:0] px);
         pixels_seen++;
         expected_indices.push_back(nearest_index(px));
      endfunction

      task check_index(logic [7:0] got);
         logic [7:0] want;
         if (expected_indices.size() == 0) begin
            report($sformatf("index word 0x%02h with nothing outstanding", got));
         end else begin
            want = expected_indices.pop_front();
            if (got !== want)
               report($sformatf("pixel_index 0x%02h, want 0x%02h", got, want));
         end
      endtask

      function int pending();
         return expected_indices.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   colour_scoreboard sb = new();
   bit tx_eager;
   bit rx_eager;
   int settings_used;

   nearest_palette_color_mapper uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),   // red_level [7:0], green_level [15:8], blue_level [23:16]
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),   // pixel_index [7:0]
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [23:0] pixel_for(logic [15:0] e, logic [2:0] low);
      return {5'(colour_scoreboard::widen_channel(e[11:9])), low,
              5'(colour_scoreboard::widen_channel(e[7:5])), low,
              5'(colour_scoreboard::widen_channel(e[3:1])), low};
   endfunction

   function automatic logic [23:0] pick_pixel();
      if ($urandom_range(0, 1)) return 24'($urandom());
      return pixel_for(sb.entry($urandom_range(0, npcm_pkg::PAL_ENTRIES - 1)),
                       3'($urandom_range(0, 7))) ^ {5'd0, 3'($urandom_range(0, 7)),
                                                    5'd0, 3'($urandom_range(0, 7)),
                                                    8'd0};
   endfunction

   task automatic write_reg(input csr_idx_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic send_pixel(input logic [23:0] px);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = px;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(px);
   endtask

   // drop valid and hold until every index word is back
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_palette(input logic [3:0][63:0] words);
      write_reg(npcm_pkg::CSR_PALETTE_0, words[0]);
      write_reg(npcm_pkg::CSR_PALETTE_1, words[1]);
      write_reg(npcm_pkg::CSR_PALETTE_2, words[2]);
      write_reg(npcm_pkg::CSR_PALETTE_3, words[3]);
      settings_used++;
   endtask

   task automatic write_mode(input logic [1:0] m);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_reg(npcm_pkg::CSR_COLOR_MODE, {junk[63:2], m});
   endtask

   // sink side: random stalls per word, none in eager phases
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rx_eager ? 0 : $urandom_range(0, 5);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_index(rsp_tdata);
      end
   end

   initial begin
      #3_000_000;
      $display("tb_nearest_palette_color_mapper NOT OK");
      $finish;
   end

   initial begin
      logic [3:0][63:0] words;
      logic [15:0] shade [2];
      logic [15:0] e;
      logic [1:0] m;
      int k, p, n, style;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tx_eager = 1'b0;
      rx_eager = 1'b0;
      settings_used = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // cleared palette: black matches entry 0, anything else ties to the last
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h070707);
      settle();

      // distinct entries with the unused bits set, entries 3 and 12 identical
      for (k = 0; k < npcm_pkg::PAL_ENTRIES; k++) begin
         e = 16'hF111 | {4'h0, 3'((7 - k) % 8), 1'b0, 3'((k / 2) % 8), 1'b0,
                         3'(k % 8), 1'b0};
         words[k / 4][(k % 4) * npcm_pkg::ENTRY_W +: npcm_pkg::ENTRY_W] = e;
      end
      words[3][15:0] = words[0][63:48];
      write_palette(words);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h00FF00);
      send_pixel(24'hFF00FF);
      send_pixel(pixel_for(sb.entry(12), 3'b111));
      send_pixel(pixel_for(sb.entry(15), 3'b000));
      settle();
      write_mode(npcm_pkg::MODE_GRAY);
      send_pixel(24'hFFFF00);
      send_pixel(24'h0000FF);
      send_pixel(24'h5A5A84);
      settle();
      write_mode(npcm_pkg::MODE_INDEXED);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hA5C35A);
      settle();
      write_mode(MODE_SPARE);
      send_pixel(24'h00003C);
      send_pixel(24'hFFFFC3);
      settle();

      // saturated palette, then writes past the last register must not land
      write_mode(npcm_pkg::MODE_TRUE);
      write_palette({4{64'hFFFF_FFFF_FFFF_FFFF}});
      for (k = 1; k <= 3; k++) write_reg(csr_idx_type'(npcm_pkg::CSR_PALETTE_3 + k), '0);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         n = $urandom_range(0, 9);
         m = (n < 5) ? npcm_pkg::MODE_TRUE : (n < 8) ? npcm_pkg::MODE_GRAY :
             (n == 8) ? npcm_pkg::MODE_INDEXED : MODE_SPARE;
         write_mode(m);
         style = $urandom_range(0, 7);
         shade[0] = 16'($urandom());
         shade[1] = 16'($urandom());
         for (k = 0; k < npcm_pkg::PAL_ENTRIES; k++) begin
            case (style)
               0: e = '0;
               1: e = '1;
               2, 3: e = shade[$urandom_range(0, 1)];
               default: e = 16'($urandom());
            endcase
            words[k / 4][(k % 4) * npcm_pkg::ENTRY_W +: npcm_pkg::ENTRY_W] = e;
         end
         write_palette(words);
         if ($urandom_range(0, 3) == 0)
            write_reg(csr_idx_type'(npcm_pkg::CSR_PALETTE_3 + $urandom_range(1, 3)),
                      {$urandom(), $urandom()});
         tx_eager = ($urandom_range(0, 3) == 0);
         rx_eager = ($urandom_range(0, 3) == 0);
         for (k = 0; k < PHASE_PIXELS; k++) send_pixel(pick_pixel());
         settle();
         tx_eager = 1'b0;
         rx_eager = 1'b0;
      end

      $display("Mapped %0d pixels under %0d palette settings and all four mode codes,",
               sb.pixels_seen, settings_used);
      $display("%0d of them landing exactly on a palette colour.", sb.exact_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_nearest_palette_color_mapper OK");
      end else begin
         $display("tb_nearest_palette_color_mapper NOT OK");
      end
      $finish;
   end

endmodule
